[src/sha256_compressed_pubkey_hash_top_assert.svh]
// Assertion macros for the compressed public key SHA-256 pipeline.
// Uses the clock and reset names of the including module; no other dependencies.
`ifndef SHA256_COMPRESSED_PUBKEY_HASH_TOP_ASSERT_SVH
`define SHA256_COMPRESSED_PUBKEY_HASH_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define S256_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define S256_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[src/s256_pkg.sv]
// Shared types and constants for the SHA-256 compressed key hash pipeline.
// No dependencies.
package s256_pkg;

   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned REQ_W      = 272;  // 264 payload bits plus one zero byte
   localparam int unsigned RSP_W      = 256;

   typedef logic [31:0] word_type;

   // Working variables a..h in hv[0]..hv[7]; w[0] is the schedule word of this round.
   typedef struct packed {
      logic [7:0][31:0]  hv;
      logic [15:0][31:0] w;
   } stage_type;

   localparam word_type H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Padding of a 33-byte message: 0x80 after the last byte, length 264 bits.
   localparam logic [23:0] PAD_AFTER_LAST = 24'h800000;
   localparam word_type    MSG_BIT_LEN    = 32'd264;

endpackage

[src/s256_round.sv]
// One SHA-256 round plus one message schedule step, registered.
// Depends on s256_pkg.
module s256_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                valid_in,
   input  s256_pkg::stage_type stage_in,
   input  s256_pkg::word_type  k_in,
   output logic                valid_out,
   output s256_pkg::stage_type stage_out
);
   import s256_pkg::*;

   function automatic word_type rotr(word_type v, int unsigned r);
      return (v >> r) | (v << (32 - r));
   endfunction

   logic      valid_ff, valid_in_d;
   stage_type stage_ff, stage_in_d;
   word_type  t1, t2, sched;
   word_type  a, b, c, e, f, g, h, d;

   always_comb begin
      a = stage_in.hv[0]; b = stage_in.hv[1]; c = stage_in.hv[2]; d = stage_in.hv[3];
      e = stage_in.hv[4]; f = stage_in.hv[5]; g = stage_in.hv[6]; h = stage_in.hv[7];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + k_in + stage_in.w[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      // word t+16 from the window t..t+15
      sched = stage_in.w[0] + stage_in.w[9]
              + (rotr(stage_in.w[1], 7) ^ rotr(stage_in.w[1], 18) ^ (stage_in.w[1] >> 3))
              + (rotr(stage_in.w[14], 17) ^ rotr(stage_in.w[14], 19) ^ (stage_in.w[14] >> 10));

      stage_in_d.hv[0] = t1 + t2;
      stage_in_d.hv[1] = a;
      stage_in_d.hv[2] = b;
      stage_in_d.hv[3] = c;
      stage_in_d.hv[4] = d + t1;
      stage_in_d.hv[5] = e;
      stage_in_d.hv[6] = f;
      stage_in_d.hv[7] = g;
      for (int i = 0; i < 15; i++) begin
         stage_in_d.w[i] = stage_in.w[i + 1];
      end
      stage_in_d.w[15] = sched;
      valid_in_d = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

[src/s256_final.sv]
// Final feed-forward add of the initial hash values and the result register.
// Depends on s256_pkg.
module s256_final (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     valid_in,
   input  s256_pkg::stage_type      stage_in,
   output logic                     rsp_valid,
   output logic [s256_pkg::RSP_W-1:0] rsp_data
);
   import s256_pkg::*;

   logic               valid_ff;
   logic [RSP_W-1:0]   data_ff, data_in;
   word_type           dig [8];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         dig[i] = stage_in.hv[i] + H_INIT[i];
      end
      // lowest field first: words 0/1, 2/3, 4/5, 6/7; even word in upper half
      data_in = {dig[6], dig[7], dig[4], dig[5], dig[2], dig[3], dig[0], dig[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[src/sha256_compressed_pubkey_hash_top.sv]
// Top level of the SHA-256 pipeline for 33-byte compressed public keys.
// Depends on s256_pkg, s256_round, s256_final and the assertion macro header.
//
// Hashes one 33-byte key per beat into its 256-bit SHA-256 digest. The key is
// padded into a single 512-bit block and run through 64 unrolled rounds, one
// register stage each, with the message schedule computed alongside. A beat
// passes 66 registers: the load stage takes it at the accepting edge, then 64
// round stages and the result register follow, after which rsp_tvalid rises.
// Throughput is one beat per cycle while the rsp side does not stall.
// All stages advance together whenever the result register is empty or its
// beat is taken, so req_tready is high exactly then; a stalled rsp side
// freezes the whole pipeline.
`include "sha256_compressed_pubkey_hash_top_assert.svh"
module sha256_compressed_pubkey_hash_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [63:0] key_bytes_0_to_7, [127:64] key_bytes_8_to_15,
   // [191:128] key_bytes_16_to_23, [255:192] key_bytes_24_to_31,
   // [263:256] key_last_byte, [271:264] zero
   input  logic [s256_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [63:0] digest_words_0_1, [127:64] digest_words_2_3,
   // [191:128] digest_words_4_5, [255:192] digest_words_6_7
   output logic [s256_pkg::RSP_W-1:0] rsp_tdata
);
   import s256_pkg::*;

   logic                enable;
   logic [NUM_ROUNDS:0] vld;
   stage_type           stg [NUM_ROUNDS+1];
   logic                load_valid_ff;
   stage_type           load_ff, load_in;

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // Load stage: padded block and initial hash values.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         load_in.hv[i] = H_INIT[i];
      end
      for (int i = 0; i < 4; i++) begin
         load_in.w[2*i]     = req_tdata[64*i+32 +: 32];
         load_in.w[2*i + 1] = req_tdata[64*i    +: 32];
      end
      load_in.w[8] = {req_tdata[263:256], PAD_AFTER_LAST};
      for (int i = 9; i < 15; i++) begin
         load_in.w[i] = '0;
      end
      load_in.w[15] = MSG_BIT_LEN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_valid_ff <= 1'b0;
      end else if (enable) begin
         load_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         load_ff <= load_in;
      end
   end

   assign vld[0] = load_valid_ff;
   assign stg[0] = load_ff;

   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      s256_round u_round (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .valid_in  (vld[r]),
         .stage_in  (stg[r]),
         .k_in      (ROUND_K[r]),
         .valid_out (vld[r+1]),
         .stage_out (stg[r+1])
      );
   end

   s256_final u_final (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .valid_in  (vld[NUM_ROUNDS]),
      .stage_in  (stg[NUM_ROUNDS]),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata)
   );

   // Assertions
   `S256_ASSERT_NEXT(a_stall_freezes, !enable, $stable(vld), "pipeline moved while stalled")
   `S256_ASSERT_NEXT(a_load_valid, req_tvalid && req_tready, load_valid_ff, "accepted beat lost at load")
   `S256_ASSERT_NEXT(a_conserve, !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready), $countones({vld, rsp_tvalid}) == $past($countones({vld, rsp_tvalid})), "beat count changed without a handshake")

endmodule

[tb/sv/tb.sv]
// Testbench for sha256_compressed_pubkey_hash_top: hashes 33-byte keys and checks each digest
// against a SHA-256 computed in the bench, under several ready/valid idling patterns.
// Depends on s256_pkg (port widths) and the DUT sources.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s256_pkg::*;

   typedef struct {
      bit [63:0] bytes_0_7;
      bit [63:0] bytes_8_15;
      bit [63:0] bytes_16_23;
      bit [63:0] bytes_24_31;
      bit [7:0]  last_byte;
   } key_type;

   typedef struct {
      bit [63:0] words_0_1;
      bit [63:0] words_2_3;
      bit [63:0] words_4_5;
      bit [63:0] words_6_7;
   } digest_type;

   localparam bit [0:7][31:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam bit [0:63][31:0] SHA_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam int PIPE_LATENCY = 66;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   digest_type expected_digests[$];
   int         send_idle_pct;
   int         rsp_stall_pct;
   int         fail_count = 0;

   sha256_compressed_pubkey_hash_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic bit [31:0] rotr(bit [31:0] v, int r);
      return (v >> r) | (v << (32 - r));
   endfunction

   // SHA-256 of the 33-byte message, padded into one 512-bit block
   function automatic digest_type sha256_of_key(key_type k);
      bit [31:0]  w [64];
      bit [31:0]  s [8];
      bit [31:0]  x, y, t1, t2;
      digest_type d;
      w[0] = k.bytes_0_7[63:32];
      w[1] = k.bytes_0_7[31:0];
      w[2] = k.bytes_8_15[63:32];
      w[3] = k.bytes_8_15[31:0];
      w[4] = k.bytes_16_23[63:32];
      w[5] = k.bytes_16_23[31:0];
      w[6] = k.bytes_24_31[63:32];
      w[7] = k.bytes_24_31[31:0];
      w[8] = {k.last_byte, 24'h800000};
      for (int i = 9; i < 15; i++)
         w[i] = 32'h0;
      w[15] = 32'd264;  // message length in bits
      for (int i = 16; i < 64; i++) begin
         x = w[i-15];
         y = w[i-2];
         w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
              + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
      end
      for (int i = 0; i < 8; i++)
         s[i] = SHA_IV[i];
      for (int i = 0; i < 64; i++) begin
         t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + SHA_K[i] + w[i];
         t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6];
         s[6] = s[5];
         s[5] = s[4];
         s[4] = s[3] + t1;
         s[3] = s[2];
         s[2] = s[1];
         s[1] = s[0];
         s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         s[i] = s[i] + SHA_IV[i];
      d.words_0_1 = {s[0], s[1]};
      d.words_2_3 = {s[2], s[3]};
      d.words_4_5 = {s[4], s[5]};
      d.words_6_7 = {s[6], s[7]};
      return d;
   endfunction

   function automatic bit [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly well-formed compressed keys; some fully random and some sparse patterns
   function automatic key_type random_key();
      key_type k;
      int      pick;
      k.bytes_0_7   = rand64();
      k.bytes_8_15  = rand64();
      k.bytes_16_23 = rand64();
      k.bytes_24_31 = rand64();
      k.last_byte   = 8'($urandom());
      pick = $urandom_range(99);
      if (pick < 70) begin
         k.bytes_0_7[63:56] = $urandom_range(1) ? 8'h03 : 8'h02;
      end else if (pick >= 85) begin
         k.bytes_0_7   = $urandom_range(1) ? 64'h0 : 64'h1 << $urandom_range(63);
         k.bytes_8_15  = $urandom_range(1) ? '1 : k.bytes_8_15;
         k.bytes_16_23 = $urandom_range(1) ? 64'h0 : k.bytes_16_23;
         k.bytes_24_31 = $urandom_range(1) ? '1 : 64'h1 << $urandom_range(63);
         k.last_byte   = $urandom_range(1) ? 8'h00 : 8'hff;
      end
      return k;
   endfunction

   // Waits out the sender idle, then holds the beat until it is taken
   task automatic send_key(key_type k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {8'h00, k.last_byte, k.bytes_24_31, k.bytes_16_23,
                     k.bytes_8_15, k.bytes_0_7};
      do @(posedge clock); while (!req_tready);
      expected_digests.push_back(sha256_of_key(k));
   endtask

   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_digests.size() != 0);
   endtask

   task automatic note_failure(string what, bit [63:0] want, bit [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digests.size() == 0) begin
            note_failure("unexpected digest beat", 64'h0, rsp_tdata[63:0]);
         end else begin
            want = expected_digests.pop_front();
            if (rsp_tdata[63:0] !== want.words_0_1)
               note_failure("digest_words_0_1", want.words_0_1, rsp_tdata[63:0]);
            if (rsp_tdata[127:64] !== want.words_2_3)
               note_failure("digest_words_2_3", want.words_2_3, rsp_tdata[127:64]);
            if (rsp_tdata[191:128] !== want.words_4_5)
               note_failure("digest_words_4_5", want.words_4_5, rsp_tdata[191:128]);
            if (rsp_tdata[255:192] !== want.words_6_7)
               note_failure("digest_words_6_7", want.words_6_7, rsp_tdata[255:192]);
         end
      end
   end

   // Field extremes, prefix bytes, and last byte values near the padding marker
   task automatic test_field_extremes();
      key_type k;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      k = '{64'h0, 64'h0, 64'h0, 64'h0, 8'h00};
      send_key(k);
      k = '{'1, '1, '1, '1, 8'hff};
      send_key(k);
      k = '{'1, 64'h0, 64'h0, 64'h0, 8'h00};
      send_key(k);
      k = '{64'h0, '1, 64'h0, 64'h0, 8'h00};
      send_key(k);
      k = '{64'h0, 64'h0, '1, 64'h0, 8'h00};
      send_key(k);
      k = '{64'h0, 64'h0, 64'h0, '1, 8'h00};
      send_key(k);
      k = '{64'h0, 64'h0, 64'h0, 64'h0, 8'hff};
      send_key(k);
      k = '{64'h0200000000000000, 64'h0, 64'h0, 64'h0, 8'h00};
      send_key(k);
      k = '{64'h03ffffffffffffff, '1, '1, '1, 8'hff};
      send_key(k);
      // prefix is not checked by the block
      k = '{64'h04aaaaaaaaaaaaaa, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
            64'h5555555555555555, 8'haa};
      send_key(k);
      k = '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
            64'haaaaaaaaaaaaaaaa, 8'h55};
      send_key(k);
      k = '{64'h8000000000000001, 64'h8000000000000001, 64'h8000000000000001,
            64'h8000000000000001, 8'h80};
      send_key(k);
      k = '{64'h0279be667ef9dcbb, 64'hac55a06295ce870b, 64'h07029bfcdb2dce28,
            64'hd959f2815b16f817, 8'h98};
      send_key(k);
      k = '{64'h0, 64'h0, 64'h0, 64'h0, 8'h01};
      send_key(k);
      k = '{64'h0, 64'h0, 64'h0, 64'h0, 8'h80};
      send_key(k);
      k = '{64'h0, 64'h0, 64'h0, 64'h1, 8'h7f};
      send_key(k);
      wait_for_digests();
   endtask

   task automatic test_random_keys(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++)
         send_key(random_key());
      wait_for_digests();
   endtask

   // Two 20-key bursts, with then without rsp stalls; each waits until every digest is back
   task automatic test_pause_and_resume();
      send_idle_pct = 0;
      rsp_stall_pct = 40;
      for (int i = 0; i < 20; i++)
         send_key(random_key());
      wait_for_digests();
      rsp_stall_pct = 0;
      for (int i = 0; i < 20; i++)
         send_key(random_key());
      wait_for_digests();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_random_keys(400, 0, 0);
      test_random_keys(400, 71, 0);
      test_pause_and_resume();
      test_random_keys(400, 0, 71);
      test_random_keys(400, 23, 23);

      repeat (PIPE_LATENCY + 14) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
